[sv/rvenc_pkg.sv]
// Shared types and encoding constants for the RV32I instruction encoder.
`default_nettype none

package rvenc_pkg;

  localparam int unsigned CodeW = 6;
  localparam int unsigned RegW  = 5;
  localparam int unsigned XLen  = 32;

  // Instruction codes, in request order
  typedef enum logic [CodeW-1:0] {
    MN_ADD    = 6'd0,  MN_SUB    = 6'd1,  MN_XOR    = 6'd2,  MN_OR     = 6'd3,
    MN_AND    = 6'd4,  MN_SLL    = 6'd5,  MN_SRL    = 6'd6,  MN_SRA    = 6'd7,
    MN_SLT    = 6'd8,  MN_SLTU   = 6'd9,
    MN_ADDI   = 6'd10, MN_XORI   = 6'd11, MN_ORI    = 6'd12, MN_ANDI   = 6'd13,
    MN_SLLI   = 6'd14, MN_SRLI   = 6'd15, MN_SRAI   = 6'd16, MN_SLTI   = 6'd17,
    MN_SLTIU  = 6'd18, MN_JALR   = 6'd19, MN_LB     = 6'd20, MN_LH     = 6'd21,
    MN_LW     = 6'd22, MN_LBU    = 6'd23, MN_LHU    = 6'd24,
    MN_SB     = 6'd25, MN_SH     = 6'd26, MN_SW     = 6'd27,
    MN_BEQ    = 6'd28, MN_BNE    = 6'd29, MN_BLT    = 6'd30, MN_BGE    = 6'd31,
    MN_BLTU   = 6'd32, MN_BGEU   = 6'd33,
    MN_JAL    = 6'd34, MN_LUI    = 6'd35, MN_AUIPC  = 6'd36,
    MN_ECALL  = 6'd37, MN_EBREAK = 6'd38
  } mnemonic_e;

  typedef enum logic [2:0] {
    FMT_R     = 3'd0,
    FMT_I     = 3'd1,
    FMT_SHIFT = 3'd2,
    FMT_S     = 3'd3,
    FMT_B     = 3'd4,
    FMT_J     = 3'd5,
    FMT_U     = 3'd6,
    FMT_FIXED = 3'd7
  } fmt_e;

  // Major opcodes
  localparam logic [6:0] OpcOp     = 7'b0110011;
  localparam logic [6:0] OpcOpImm  = 7'b0010011;
  localparam logic [6:0] OpcJalr   = 7'b1100111;
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcJal    = 7'b1101111;
  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [6:0] OpcAuipc  = 7'b0010111;
  localparam logic [6:0] OpcSystem = 7'b1110011;

  localparam logic [6:0] F7Zero = 7'b0000000;
  localparam logic [6:0] F7Alt  = 7'b0100000;

  localparam logic [XLen-1:0] WordEcall  = 32'h0000_0073;
  localparam logic [XLen-1:0] WordEbreak = 32'b00000000000100000000000001110011;

  typedef struct packed {
    logic       known;
    fmt_e       fmt;
    logic [6:0] opcode;
    logic [2:0] funct3;
    logic [6:0] funct7;
    logic       brk;     // fixed word: ebreak rather than ecall
  } desc_t;

  typedef struct packed {
    logic [XLen-1:0] target_address;
    logic [XLen-1:0] inst_address;
    logic [XLen-1:0] immediate;
    logic [RegW-1:0] src2_reg;
    logic [RegW-1:0] src1_reg;
    logic [RegW-1:0] dest_reg;
    logic [CodeW-1:0] mnemonic;
  } req_t;

endpackage

`default_nettype wire

[sv/rvenc_decode.sv]
// Mnemonic code to format/opcode/funct descriptor lookup.
`default_nettype none

module rvenc_decode (
  input  wire logic [rvenc_pkg::CodeW-1:0] code_i,
  output rvenc_pkg::desc_t                  desc_o
);

  always_comb begin
    desc_o        = '0;
    desc_o.known  = 1'b1;
    desc_o.fmt    = rvenc_pkg::FMT_FIXED;
    unique case (code_i)
      rvenc_pkg::MN_ADD, rvenc_pkg::MN_SUB, rvenc_pkg::MN_XOR, rvenc_pkg::MN_OR,
      rvenc_pkg::MN_AND, rvenc_pkg::MN_SLL, rvenc_pkg::MN_SRL, rvenc_pkg::MN_SRA,
      rvenc_pkg::MN_SLT, rvenc_pkg::MN_SLTU: begin
        desc_o.fmt    = rvenc_pkg::FMT_R;
        desc_o.opcode = rvenc_pkg::OpcOp;
      end
      rvenc_pkg::MN_ADDI, rvenc_pkg::MN_XORI, rvenc_pkg::MN_ORI, rvenc_pkg::MN_ANDI,
      rvenc_pkg::MN_SLTI, rvenc_pkg::MN_SLTIU: begin
        desc_o.fmt    = rvenc_pkg::FMT_I;
        desc_o.opcode = rvenc_pkg::OpcOpImm;
      end
      rvenc_pkg::MN_SLLI, rvenc_pkg::MN_SRLI, rvenc_pkg::MN_SRAI: begin
        desc_o.fmt    = rvenc_pkg::FMT_SHIFT;
        desc_o.opcode = rvenc_pkg::OpcOpImm;
      end
      rvenc_pkg::MN_JALR: begin
        desc_o.fmt    = rvenc_pkg::FMT_I;
        desc_o.opcode = rvenc_pkg::OpcJalr;
      end
      rvenc_pkg::MN_LB, rvenc_pkg::MN_LH, rvenc_pkg::MN_LW, rvenc_pkg::MN_LBU,
      rvenc_pkg::MN_LHU: begin
        desc_o.fmt    = rvenc_pkg::FMT_I;
        desc_o.opcode = rvenc_pkg::OpcLoad;
      end
      rvenc_pkg::MN_SB, rvenc_pkg::MN_SH, rvenc_pkg::MN_SW: begin
        desc_o.fmt    = rvenc_pkg::FMT_S;
        desc_o.opcode = rvenc_pkg::OpcStore;
      end
      rvenc_pkg::MN_BEQ, rvenc_pkg::MN_BNE, rvenc_pkg::MN_BLT, rvenc_pkg::MN_BGE,
      rvenc_pkg::MN_BLTU, rvenc_pkg::MN_BGEU: begin
        desc_o.fmt    = rvenc_pkg::FMT_B;
        desc_o.opcode = rvenc_pkg::OpcBranch;
      end
      rvenc_pkg::MN_JAL: begin
        desc_o.fmt    = rvenc_pkg::FMT_J;
        desc_o.opcode = rvenc_pkg::OpcJal;
      end
      rvenc_pkg::MN_LUI: begin
        desc_o.fmt    = rvenc_pkg::FMT_U;
        desc_o.opcode = rvenc_pkg::OpcLui;
      end
      rvenc_pkg::MN_AUIPC: begin
        desc_o.fmt    = rvenc_pkg::FMT_U;
        desc_o.opcode = rvenc_pkg::OpcAuipc;
      end
      rvenc_pkg::MN_ECALL: begin
        desc_o.opcode = rvenc_pkg::OpcSystem;
      end
      rvenc_pkg::MN_EBREAK: begin
        desc_o.opcode = rvenc_pkg::OpcSystem;
        desc_o.brk    = 1'b1;
      end
      default: begin
        desc_o.known = 1'b0;
      end
    endcase

    // funct3 / funct7 per instruction
    case (code_i)
      rvenc_pkg::MN_XOR, rvenc_pkg::MN_XORI, rvenc_pkg::MN_LBU,
      rvenc_pkg::MN_BLT:                          desc_o.funct3 = 3'd4;
      rvenc_pkg::MN_OR, rvenc_pkg::MN_ORI,
      rvenc_pkg::MN_BLTU:                         desc_o.funct3 = 3'd6;
      rvenc_pkg::MN_AND, rvenc_pkg::MN_ANDI,
      rvenc_pkg::MN_BGEU:                         desc_o.funct3 = 3'd7;
      rvenc_pkg::MN_SLL, rvenc_pkg::MN_SLLI, rvenc_pkg::MN_LH,
      rvenc_pkg::MN_SH, rvenc_pkg::MN_BNE:        desc_o.funct3 = 3'd1;
      rvenc_pkg::MN_SRL, rvenc_pkg::MN_SRA, rvenc_pkg::MN_SRLI,
      rvenc_pkg::MN_SRAI, rvenc_pkg::MN_LHU,
      rvenc_pkg::MN_BGE:                          desc_o.funct3 = 3'd5;
      rvenc_pkg::MN_SLT, rvenc_pkg::MN_SLTI, rvenc_pkg::MN_LW,
      rvenc_pkg::MN_SW:                           desc_o.funct3 = 3'd2;
      rvenc_pkg::MN_SLTU, rvenc_pkg::MN_SLTIU:    desc_o.funct3 = 3'd3;
      default:                                    desc_o.funct3 = 3'd0;
    endcase

    if (code_i == rvenc_pkg::MN_SUB || code_i == rvenc_pkg::MN_SRA ||
        code_i == rvenc_pkg::MN_SRAI) begin
      desc_o.funct7 = rvenc_pkg::F7Alt;
    end else begin
      desc_o.funct7 = rvenc_pkg::F7Zero;
    end
  end

endmodule

`default_nettype wire

[sv/rvenc_pack.sv]
// Packs the decoded fields, registers and immediate/offset into the machine word.
`default_nettype none

module rvenc_pack (
  input  wire rvenc_pkg::desc_t            desc_i,
  input  wire rvenc_pkg::req_t             req_i,
  output logic [rvenc_pkg::XLen-1:0]       word_o
);

  logic [rvenc_pkg::XLen-1:0] off;
  logic [rvenc_pkg::XLen-1:0] imm;
  logic [rvenc_pkg::RegW-1:0] rd, rs1, rs2;
  logic [2:0]                 f3;
  logic [6:0]                 f7, opc;

  // branch / jal offset, wraps modulo 2^32
  assign off = req_i.target_address - req_i.inst_address;
  assign imm = req_i.immediate;
  assign rd  = req_i.dest_reg;
  assign rs1 = req_i.src1_reg;
  assign rs2 = req_i.src2_reg;
  assign f3  = desc_i.funct3;
  assign f7  = desc_i.funct7;
  assign opc = desc_i.opcode;

  always_comb begin
    word_o = '0;
    if (desc_i.known) begin
      case (desc_i.fmt)
        rvenc_pkg::FMT_R:     word_o = {f7, rs2, rs1, f3, rd, opc};
        rvenc_pkg::FMT_I:     word_o = {imm[11:0], rs1, f3, rd, opc};
        rvenc_pkg::FMT_SHIFT: word_o = {f7, imm[4:0], rs1, f3, rd, opc};
        rvenc_pkg::FMT_S:     word_o = {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
        rvenc_pkg::FMT_B:     word_o = {off[12], off[10:5], rs2, rs1, f3,
                                        off[4:1], off[11], opc};
        rvenc_pkg::FMT_J:     word_o = {off[20], off[10:1], off[11], off[19:12],
                                        rd, opc};
        rvenc_pkg::FMT_U:     word_o = {imm[19:0], rd, opc};
        default:              word_o = desc_i.brk ? rvenc_pkg::WordEbreak
                                                  : rvenc_pkg::WordEcall;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/rv32i_instruction_encoder.sv]
// RV32I instruction encoder top level: request register, encode logic, result register.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------
//  request  | in  | s_axis_tvalid/s_axis_tready  | s_axis_tdata[116:0] (7 fields)
//  result   | out | m_axis_tvalid/m_axis_tready  | m_axis_tdata word, m_axis_tuser err
//
//  One beat per cycle sustained while m_axis_tready stays high.
//  Path: request register -> decode + 32-bit offset subtract + pack -> result register.
//  Reset (rst_ni low, async) empties both stages; no other state.
//  A stalled result holds; the request stage keeps moving while the result stage has room.
`default_nettype none

module rv32i_instruction_encoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [5:0] mnemonic, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
  // [52:21] immediate, [84:53] inst_address, [116:85] target_address, [119:117] zero
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] machine_word
  output logic [31:0]       m_axis_tdata,
  // [0] unknown_op
  output logic              m_axis_tuser
);

  localparam int unsigned ReqW = $bits(rvenc_pkg::req_t);

  rvenc_pkg::req_t            req_q;
  logic                       req_vld_q;
  logic [rvenc_pkg::XLen-1:0] word_q;
  logic                       unk_q;
  logic                       res_vld_q;

  rvenc_pkg::desc_t           desc;
  logic [rvenc_pkg::XLen-1:0] word_d;
  logic                       res_load;

  assign res_load      = !res_vld_q || m_axis_tready;
  assign s_axis_tready = !req_vld_q || res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        req_vld_q <= s_axis_tvalid;
      end
      if (res_load) begin
        res_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= rvenc_pkg::req_t'(s_axis_tdata[ReqW-1:0]);
    end
    if (res_load && req_vld_q) begin
      word_q <= word_d;
      unk_q  <= !desc.known;
    end
  end

  rvenc_decode u_decode (
    .code_i (req_q.mnemonic),
    .desc_o (desc)
  );

  rvenc_pack u_pack (
    .desc_i (desc),
    .req_i  (req_q),
    .word_o (word_d)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = word_q;
  assign m_axis_tuser  = unk_q;

endmodule

`default_nettype wire

[sv/rvenc_checker.sv]
// Port-level checks for the RV32I instruction encoder, bound to the top level.
`default_nettype none

module rvenc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata,
  input wire logic         m_axis_tuser
);

  // an unknown code always comes out as an all-zero word
  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("unknown_op beat with nonzero word");

  // every valid encoding carries a 32-bit opcode (low bits 11)
  a_opc_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[1:0] == 2'b11))
    else $error("encoded word lacks 32-bit opcode marker");

  // with the result side empty the request side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request stalled while result stage is empty");

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind rv32i_instruction_encoder rvenc_checker u_rvenc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
